[rtl/crcbf_pkg.sv]
`default_nettype none

package crcbf_pkg;

    // Folding constants that advance the state by 64 bits.
    localparam logic [31:0] FOLD_K_LO  = 32'h493c7d27;
    localparam logic [31:0] FOLD_K_HI  = 32'hdd45aab8;

    // Barrett constants for the reflected Castagnoli polynomial.
    localparam logic [31:0] BARRETT_MU = 32'hdea713f1;
    localparam logic [31:0] BARRETT_P  = 32'h05ec76f1;
    localparam logic [31:0] ALL_ONES32 = 32'hffffffff;

    // Byte count of a full word, which takes the folding path.
    localparam logic [3:0]  FULL_COUNT = 4'd8;

    // Number of zero-word reductions that close out a 64-bit state.
    localparam logic [1:0]  FULL_REDUCE_STEPS = 2'd2;

    // One classified request as it waits between the front and the back.
    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  byte_count;
        logic        first;
        logic        last;
        logic        full;
        logic        skip;
    } crcbf_item_t;

    // Sequencer states of the back end.
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DISPATCH,
        BK_RED_A,
        BK_RED_B,
        BK_FOLD_A,
        BK_FOLD_B,
        BK_EMIT
    } crcbf_state_t;

    // Kind of Barrett reduction that is in flight.
    typedef enum logic [1:0] {
        OP_ZERO,
        OP_WORD,
        OP_BYTE
    } crcbf_op_t;

    // Carryless product of two 32-bit words.
    function automatic logic [63:0] clmul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] acc;
        acc = '0;
        for (int k = 0; k < 32; k++) begin
            if (b[k]) begin
                acc = acc ^ ({32'b0, a} << k);
            end
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

[rtl/crcbf_ifs.sv]
`default_nettype none

// Request channel: message words with their framing marks.
interface crcbf_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        first;
    logic        last;

    modport source (output valid, output data_word, output byte_count,
                    output first, output last, input ready);
    modport sink   (input valid, input data_word, input byte_count,
                    input first, input last, output ready);
endinterface

// Result channel: one CRC per message.
interface crcbf_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] crc_value;

    modport source (output valid, output crc_value, input ready);
    modport sink   (input valid, input crc_value, output ready);
endinterface

`default_nettype wire

[rtl/crcbf_front.sv]
`default_nettype none

module crcbf_front
    import crcbf_pkg::*;
#(
    parameter int WORD_BYTES = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    crcbf_in_if.sink     req,
    output crcbf_item_t  item,
    output logic         item_vld,
    input  logic         item_pop
);

    localparam logic [3:0] WB = 4'(WORD_BYTES);

    crcbf_item_t entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  fill_reg;
    logic [1:0]  fill_next;
    crcbf_item_t incoming;
    logic        push;
    logic [3:0]  cnt_sat;

    // Saturate the byte count and classify the request.
    always_comb
    begin
        cnt_sat             = (req.byte_count > WB) ? WB : req.byte_count;
        incoming.data_word  = req.data_word;
        incoming.byte_count = cnt_sat;
        incoming.first      = req.first;
        incoming.last       = req.last;
        incoming.full       = (cnt_sat == FULL_COUNT);
        incoming.skip       = (cnt_sat == 4'd0) && !req.last;
    end

    assign req.ready = (fill_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign item_vld  = (fill_reg != 2'd0);
    assign item      = entry_reg[rd_ptr_reg];

    // Two-entry queue pointers and fill level.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ (item_pop && item_vld);
        fill_next   = fill_reg + {1'b0, push} - {1'b0, item_pop && item_vld};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

`default_nettype wire

[rtl/crcbf_back.sv]
`default_nettype none

module crcbf_back
    import crcbf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data,
    input  crcbf_item_t  item,
    input  logic         item_vld,
    output logic         item_pop,
    crcbf_out_if.source  res
);

    crcbf_state_t state_reg, state_next;
    logic [31:0]  seed_reg;
    logic [63:0]  st_reg, st_next;
    logic         pend_reg, pend_next;
    logic [63:0]  data_reg, data_next;
    logic [3:0]   cnt_reg, cnt_next;
    logic         last_reg, last_next;
    logic         full_reg, full_next;
    logic [3:0]   pos_reg, pos_next;
    logic [1:0]   zero_left_reg, zero_left_next;
    logic         fold_req_reg, fold_req_next;
    logic         main_done_reg, main_done_next;
    crcbf_op_t    op_reg, op_next;
    logic [31:0]  w_reg, w_next;
    logic [31:0]  q_reg, q_next;
    logic [63:0]  acc_reg, acc_next;
    logic         out_vld_reg, out_vld_next;
    logic [31:0]  crc_reg, crc_next;

    logic [63:0]  st_base;
    logic         pend_base;
    logic [31:0]  red_c;
    logic [31:0]  mul_a;
    logic [31:0]  mul_b;
    logic [63:0]  mul_p;
    logic [7:0]   cur_byte;

    assign res.valid     = out_vld_reg;
    assign res.crc_value = crc_reg;

    // Barrett input word: a whole word, or one byte moved to the top.
    always_comb
    begin
        if (op_reg == OP_BYTE)
        begin
            red_c = {st_reg[7:0] ^ w_reg[7:0], 24'b0};
        end
        else
        begin
            red_c = st_reg[31:0] ^ w_reg;
        end
    end

    // The single carryless multiplier, shared by the reduction and fold steps.
    always_comb
    begin
        case (state_reg)
            BK_RED_A:
            begin
                mul_a = red_c;
                mul_b = BARRETT_MU;
            end
            BK_RED_B:
            begin
                mul_a = q_reg;
                mul_b = BARRETT_P;
            end
            BK_FOLD_A:
            begin
                mul_a = st_reg[31:0];
                mul_b = FOLD_K_LO;
            end
            BK_FOLD_B:
            begin
                mul_a = st_reg[63:32];
                mul_b = FOLD_K_HI;
            end
            default:
            begin
                mul_a = 32'b0;
                mul_b = 32'b0;
            end
        endcase
        mul_p = clmul32(mul_a, mul_b);
    end

    assign cur_byte  = data_reg[{pos_reg[2:0], 3'b000} +: 8];
    assign st_base   = item.first ? {32'b0, seed_reg ^ ALL_ONES32} : st_reg;
    assign pend_base = item.first ? 1'b0 : pend_reg;

    // Sequencer: next state and register updates.
    always_comb
    begin
        state_next     = state_reg;
        st_next        = st_reg;
        pend_next      = pend_reg;
        data_next      = data_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        full_next      = full_reg;
        pos_next       = pos_reg;
        zero_left_next = zero_left_reg;
        fold_req_next  = fold_req_reg;
        main_done_next = main_done_reg;
        op_next        = op_reg;
        w_next         = w_reg;
        q_next         = q_reg;
        acc_next       = acc_reg;
        crc_next       = crc_reg;
        out_vld_next   = out_vld_reg && !res.ready;
        item_pop       = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (item_vld)
                begin
                    item_pop = 1'b1;
                    st_next  = st_base;
                    if (item.skip)
                    begin
                        pend_next = pend_base;
                    end
                    else
                    begin
                        pend_next      = 1'b0;
                        data_next      = item.data_word;
                        cnt_next       = item.byte_count;
                        last_next      = item.last;
                        full_next      = item.full;
                        pos_next       = 4'd0;
                        main_done_next = 1'b0;
                        fold_req_next  = pend_base && item.full;
                        zero_left_next = (pend_base && !item.full) ? FULL_REDUCE_STEPS
                                                                   : 2'd0;
                        state_next     = BK_DISPATCH;
                    end
                end
            end

            BK_DISPATCH:
            begin
                if (fold_req_reg)
                begin
                    state_next = BK_FOLD_A;
                end
                else if (zero_left_reg != 2'd0)
                begin
                    op_next    = OP_ZERO;
                    w_next     = 32'b0;
                    state_next = BK_RED_A;
                end
                else if (!main_done_reg)
                begin
                    if (full_reg)
                    begin
                        // A full word is absorbed; it is folded or reduced later.
                        st_next        = st_reg ^ data_reg;
                        main_done_next = 1'b1;
                        if (last_reg)
                        begin
                            zero_left_next = FULL_REDUCE_STEPS;
                        end
                        else
                        begin
                            pend_next = 1'b1;
                        end
                    end
                    else if ((cnt_reg >= 4'd4) && (pos_reg == 4'd0))
                    begin
                        op_next    = OP_WORD;
                        w_next     = data_reg[31:0];
                        state_next = BK_RED_A;
                    end
                    else if (pos_reg < cnt_reg)
                    begin
                        op_next    = OP_BYTE;
                        w_next     = {24'b0, cur_byte};
                        state_next = BK_RED_A;
                    end
                    else
                    begin
                        main_done_next = 1'b1;
                    end
                end
                else if (last_reg)
                begin
                    state_next = BK_EMIT;
                end
                else
                begin
                    state_next = BK_IDLE;
                end
            end

            BK_RED_A:
            begin
                q_next     = mul_p[31:0];
                state_next = BK_RED_B;
            end

            BK_RED_B:
            begin
                if (op_reg == OP_BYTE)
                begin
                    st_next  = (st_reg >> 8) ^ {32'b0, mul_p[63:32] ^ q_reg};
                    pos_next = pos_reg + 4'd1;
                end
                else
                begin
                    st_next = (st_reg >> 32) ^ {32'b0, mul_p[63:32] ^ q_reg};
                    if (op_reg == OP_ZERO)
                    begin
                        zero_left_next = zero_left_reg - 2'd1;
                    end
                    else
                    begin
                        pos_next = 4'd4;
                    end
                end
                state_next = BK_DISPATCH;
            end

            BK_FOLD_A:
            begin
                acc_next   = mul_p;
                state_next = BK_FOLD_B;
            end

            BK_FOLD_B:
            begin
                st_next       = acc_reg ^ mul_p;
                fold_req_next = 1'b0;
                state_next    = BK_DISPATCH;
            end

            BK_EMIT:
            begin
                // Wait until the output register is free.
                if (!out_vld_reg || res.ready)
                begin
                    crc_next     = st_reg[31:0] ^ ALL_ONES32;
                    out_vld_next = 1'b1;
                    state_next   = BK_IDLE;
                end
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            seed_reg      <= 32'b0;
            st_reg        <= 64'b0;
            pend_reg      <= 1'b0;
            zero_left_reg <= 2'd0;
            fold_req_reg  <= 1'b0;
            main_done_reg <= 1'b0;
            pos_reg       <= 4'd0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            st_reg        <= st_next;
            pend_reg      <= pend_next;
            zero_left_reg <= zero_left_next;
            fold_req_reg  <= fold_req_next;
            main_done_reg <= main_done_next;
            pos_reg       <= pos_next;
            out_vld_reg   <= out_vld_next;
            if (cfg_wr_en)
            begin
                seed_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        cnt_reg  <= cnt_next;
        last_reg <= last_next;
        full_reg <= full_next;
        op_reg   <= op_next;
        w_reg    <= w_next;
        q_reg    <= q_next;
        acc_reg  <= acc_next;
        crc_reg  <= crc_next;
    end

endmodule

`default_nettype wire

[rtl/crc32c_barrett_fold_engine.sv]
// CRC-32C engine (reflected Castagnoli) with a 64-bit folding state.
//
// Requests arrive on req: data_word with byte zero in the low bits, byte_count
// valid bytes (counts above WORD_BYTES saturate), and first and last marks.
// A request with last set produces one result on res: the final inverted CRC.
// The user writes the seed register via cfg_wr_en and cfg_wr_data while idle;
// the block does not enforce it. A first word starts from the inverted seed.
//
// A front end classifies requests into a two-entry queue; the back end runs
// them through one shared 32 by 32 carryless multiplier. Each Barrett
// reduction passes through dispatch and two multiplies, as does a pending
// 64-bit fold, and a final word also loads the result register. The multiplier
// is the limiting resource.
//
// Reset clears the folding state, the seed and the queue. When the receiver
// stalls, the result waits in the output register; the back end only holds in
// its result state with a further result; the queue takes requests until full.
`default_nettype none

module crc32c_barrett_fold_engine
    import crcbf_pkg::*;
#(
    parameter int WORD_BYTES = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data,
    crcbf_in_if.sink     req,
    crcbf_out_if.source  res
);

    crcbf_item_t item;
    logic        item_vld;
    logic        item_pop;

    // Intake and queue.
    crcbf_front #(
        .WORD_BYTES (WORD_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .item     (item),
        .item_vld (item_vld),
        .item_pop (item_pop)
    );

    // Reduction sequencer and result register.
    crcbf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item),
        .item_vld    (item_vld),
        .item_pop    (item_pop),
        .res         (res)
    );

endmodule

`default_nettype wire
